>>> src/qet_pkg.sv
package qet_pkg;

  localparam int SET_SLOTS = 8;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_DELIM = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DROP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       final_res;
  } out_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } res_t;

  // Up to two results caused by one item.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } act_t;

  function automatic logic set_has(input logic [CFG_W-1:0] set, input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < SET_SLOTS; i++) begin
      if (set[8*i +: 8] == c) begin
        hit = 1'b1;
      end
    end
    return hit && (c != 8'd0);
  endfunction

endpackage

>>> src/qet_front.sv
module qet_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  qet_pkg::in_t                    in_data,
  input  logic                            cfg_we,
  input  logic [qet_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qet_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            q_full,
  output logic                            q_wr,
  output qet_pkg::act_t                   q_wdata
);

  logic [qet_pkg::CFG_W-1:0] drop_delims;
  logic [qet_pkg::CFG_W-1:0] keep_delims;
  logic [qet_pkg::CFG_W-1:0] quote_chars;
  logic [qet_pkg::CFG_W-1:0] escape_chars;

  logic       in_quote;
  logic [7:0] open_quote_char;
  logic       escape_pending;
  logic       token_open;

  logic       in_quote_next;
  logic [7:0] open_quote_char_next;
  logic       escape_pending_next;
  logic       token_open_next;

  logic       accept;
  logic [7:0] c;
  logic       eot;
  logic       add;
  logic       complete;
  logic       delim;
  logic       flush;
  logic       tok1;
  logic [1:0] cnt;
  qet_pkg::act_t act;

  assign accept = push && !q_full;
  assign full = q_full;
  assign c = in_data.ch;
  assign eot = in_data.end_of_text;

  always_comb begin
    in_quote_next = in_quote;
    open_quote_char_next = open_quote_char;
    escape_pending_next = escape_pending;
    add = 1'b0;
    complete = 1'b0;
    delim = 1'b0;
    if (escape_pending) begin
      escape_pending_next = 1'b0;
      add = 1'b1;
    end else if (qet_pkg::set_has(escape_chars, c)) begin
      escape_pending_next = !eot;
    end else begin
      add = 1'b1;
      if (qet_pkg::set_has(quote_chars, c)) begin
        if (!in_quote) begin
          in_quote_next = 1'b1;
          open_quote_char_next = c;
          add = 1'b0;
        end else if (open_quote_char == c) begin
          in_quote_next = 1'b0;
          open_quote_char_next = 8'd0;
          add = 1'b0;
        end
      end
      if (!in_quote_next && qet_pkg::set_has(drop_delims, c)) begin
        complete = token_open;
        add = 1'b0;
      end
      if (!in_quote_next && qet_pkg::set_has(keep_delims, c)) begin
        complete = token_open;
        add = 1'b0;
        delim = 1'b1;
      end
    end

    tok1 = add ? 1'b1 : (complete ? 1'b0 : token_open);
    flush = eot && tok1;
    token_open_next = tok1;
    if (eot) begin
      in_quote_next = 1'b0;
      open_quote_char_next = 8'd0;
      escape_pending_next = 1'b0;
      token_open_next = 1'b0;
    end

    act = '0;
    cnt = 2'd0;
    if (add) begin
      act.r0 = '{kind: qet_pkg::KIND_CHAR, value: c};
      cnt = 2'd1;
    end
    if (complete) begin
      if (cnt == 2'd0) begin
        act.r0 = '{kind: qet_pkg::KIND_END, value: 8'd0};
      end else begin
        act.r1 = '{kind: qet_pkg::KIND_END, value: 8'd0};
      end
      cnt = cnt + 2'd1;
    end
    if (delim) begin
      if (cnt == 2'd0) begin
        act.r0 = '{kind: qet_pkg::KIND_DELIM, value: c};
      end else begin
        act.r1 = '{kind: qet_pkg::KIND_DELIM, value: c};
      end
      cnt = cnt + 2'd1;
    end
    if (flush) begin
      if (cnt == 2'd0) begin
        act.r0 = '{kind: qet_pkg::KIND_END, value: 8'd0};
      end else begin
        act.r1 = '{kind: qet_pkg::KIND_END, value: 8'd0};
      end
      cnt = cnt + 2'd1;
    end
    act.two = cnt[1];
  end

  assign q_wr = accept && (cnt != 2'd0);
  assign q_wdata = act;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_delims <= '0;
      keep_delims <= '0;
      quote_chars <= '0;
      escape_chars <= '0;
      in_quote <= 1'b0;
      open_quote_char <= 8'd0;
      escape_pending <= 1'b0;
      token_open <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          qet_pkg::CFG_DROP: drop_delims <= cfg_data;
          qet_pkg::CFG_KEEP: keep_delims <= cfg_data;
          qet_pkg::CFG_QUOTE: quote_chars <= cfg_data;
          qet_pkg::CFG_ESCAPE: escape_chars <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        in_quote <= in_quote_next;
        open_quote_char <= open_quote_char_next;
        escape_pending <= escape_pending_next;
        token_open <= token_open_next;
      end
    end
  end

endmodule

>>> src/qet_queue.sv
module qet_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  qet_pkg::act_t wdata,
  output logic          full,
  input  logic          rd,
  output qet_pkg::act_t rdata,
  output logic          empty
);

  qet_pkg::act_t                   slots [qet_pkg::QUEUE_DEPTH];
  logic [qet_pkg::QUEUE_PTR_W-1:0] head;
  logic [qet_pkg::QUEUE_PTR_W-1:0] tail;
  logic [qet_pkg::QUEUE_PTR_W:0]   count;
  logic                            do_wr;
  logic                            do_rd;

  assign full = (count == (qet_pkg::QUEUE_PTR_W + 1)'(qet_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slots[head];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[tail] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        tail <= tail + 1'b1;
      end
      if (do_rd) begin
        head <= head + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/qet_back.sv
module qet_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  output logic          q_rd,
  input  qet_pkg::act_t q_rdata,
  output logic          empty,
  input  logic          pop,
  output qet_pkg::out_t out_data
);

  qet_pkg::act_t cur;
  logic          cur_valid;
  logic          phase;
  logic          last;
  logic          take;
  qet_pkg::res_t res;

  assign last = phase || !cur.two;
  assign take = !cur_valid || (pop && last);
  assign q_rd = take && !q_empty;
  assign res = phase ? cur.r1 : cur.r0;
  assign empty = !cur_valid;
  assign out_data = '{kind: res.kind, value: res.value, final_res: last};

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase <= 1'b0;
    end else if (take) begin
      cur_valid <= !q_empty;
      phase <= 1'b0;
    end else if (pop) begin
      phase <= 1'b1;
    end
  end

endmodule

>>> src/quoted_escaped_tokenizer_top.sv
// Splits a character stream into tokens using four configured byte sets.
// Input channel: one character and its end-of-text mark per item, taken at
// a clock edge with push high and full low. Result channel: the oldest
// result item sits on out_data while empty is low and leaves at an edge
// with pop high. An item causes zero, one or two result items; final_res
// marks the last result of each item.
// Configuration: cfg_we, cfg_index and cfg_data write one set register at
// a clock edge; write only while no item is in flight.
// A result passes from the accepting edge into the queue and from there into
// the result register of the output stage before it is on out_data.
// Throughput: one item per cycle on the input while full is low and one
// result per cycle on the output while empty is low; an item with two
// results needs two pops, and the single result register sets the rate.
// A four-entry queue between the classifier and the output stage absorbs
// short stalls; when the receiver holds pop low the queue fills and full
// rises. Reset clears the set registers, the tokenizer state and the queue.
module quoted_escaped_tokenizer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  qet_pkg::in_t                  in_data,
  output logic                          empty,
  input  logic                          pop,
  output qet_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [qet_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qet_pkg::CFG_W-1:0]     cfg_data
);

  logic          q_full;
  logic          q_wr;
  qet_pkg::act_t q_wdata;
  logic          q_rd;
  logic          q_empty;
  qet_pkg::act_t q_rdata;

  qet_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wdata   (q_wdata)
  );

  qet_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  qet_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_rd     (q_rd),
    .q_rdata  (q_rdata),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_wr |-> !q_full)
    else $error("queue written while full");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present right after reset");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
      (!empty && out_data.kind == qet_pkg::KIND_END) |-> out_data.value == 8'd0)
    else $error("end-of-token result carries a character");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
      !empty |-> (out_data.kind == qet_pkg::KIND_CHAR || out_data.kind == qet_pkg::KIND_END
                  || out_data.kind == qet_pkg::KIND_DELIM))
    else $error("illegal result kind");
`endif

endmodule
